// ===== src/ntt_pkg.sv =====
`timescale 1ns / 1ps

package ntt_pkg;

    // table and arithmetic constants
    localparam int NTC_TABLE_LEN     = 35;
    localparam int DEF_TABLE_ENTRIES = 35;
    localparam int NTC_IDX_W         = 6;
    localparam int SAMPLE_W          = 10;
    localparam int V_W               = 9;
    localparam int OHMS_W            = 23;
    localparam int TEMP_W            = 9;
    localparam int MUL_B_W           = 14;
    localparam int PROD_W            = SAMPLE_W + MUL_B_W;
    localparam int DIV_W             = 23;
    localparam int DVS_W             = 15;
    localparam int DIV_STEPS         = DIV_W;
    localparam int CNT_W             = $clog2(DIV_STEPS);
    localparam int IN_DATA_W         = 16;
    localparam int OUT_DATA_W        = 32;

    localparam int ADC_SCALE   = 322;
    localparam int SCALE_DIV   = 1000;
    localparam int SERIES_OHMS = 13000;
    localparam int REF_CV      = 330;
    localparam int V_MAX       = 329;
    localparam int TEMP_MIN    = -40;
    localparam int TEMP_MAX    = 130;
    localparam int TEMP_STEP   = 5;

    // divide by 1000 as ceil(2^29 / 1000) then a shift by 29, exact below 2^19
    localparam int V_RECIP        = 536871;
    localparam int V_RECIP_W      = 20;
    localparam int V_RECIP_SH     = 29;
    localparam int V_RECIP_PROD_W = DIV_W + V_RECIP_W;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_V,
        ST_SCALE_V,
        ST_MUL_R,
        ST_DIVR_INIT,
        ST_DIV_R,
        ST_SRCH_INIT,
        ST_SEARCH,
        ST_DIV_T,
        ST_TEMP,
        ST_FINISH
    } t_ctrl_state;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_MUL_V,
        OP_SCALE_V,
        OP_DIV_STEP,
        OP_MUL_R,
        OP_DIVR_INIT,
        OP_SRCH_INIT,
        OP_SRCH_STEP,
        OP_DIVT_INIT,
        OP_TEMP_HOT,
        OP_TEMP_INTERP,
        OP_PUSH
    } t_dp_op;

    typedef struct packed {
        t_dp_op op;
    } t_dp_cmd;

    typedef struct packed {
        logic below;     // table entry at the search index lies below the resistance
        logic last_idx;  // search index is the last entry searched
        logic out_free;  // output register can take a result this cycle
    } t_dp_status;

    // resistance curve in ohms, -40 C to 130 C in 5 degree steps
    function automatic logic [OHMS_W-1:0] ntc_curve(input logic [NTC_IDX_W-1:0] idx);
        logic [OHMS_W-1:0] r;
        case (idx)
            6'd0:    r = 23'd348500;
            6'd1:    r = 23'd249962;
            6'd2:    r = 23'd181385;
            6'd3:    r = 23'd133090;
            6'd4:    r = 23'd98691;
            6'd5:    r = 23'd73923;
            6'd6:    r = 23'd55905;
            6'd7:    r = 23'd42668;
            6'd8:    r = 23'd32851;
            6'd9:    r = 23'd25504;
            6'd10:   r = 23'd19959;
            6'd11:   r = 23'd15739;
            6'd12:   r = 23'd12502;
            6'd13:   r = 23'd10000;
            6'd14:   r = 23'd8052;
            6'd15:   r = 23'd6525;
            6'd16:   r = 23'd5321;
            6'd17:   r = 23'd4364;
            6'd18:   r = 23'd3599;
            6'd19:   r = 23'd2984;
            6'd20:   r = 23'd2488;
            6'd21:   r = 23'd2084;
            6'd22:   r = 23'd1754;
            6'd23:   r = 23'd1483;
            6'd24:   r = 23'd1260;
            6'd25:   r = 23'd1074;
            6'd26:   r = 23'd920;
            6'd27:   r = 23'd791;
            6'd28:   r = 23'd683;
            6'd29:   r = 23'd591;
            6'd30:   r = 23'd514;
            6'd31:   r = 23'd448;
            6'd32:   r = 23'd392;
            6'd33:   r = 23'd344;
            6'd34:   r = 23'd303;
            default: r = '0;
        endcase
        return r;
    endfunction

    // per-degree slope below each entry: (curve[i-1] - curve[i]) / 5, truncated
    function automatic logic [DVS_W-1:0] ntc_slope(input logic [NTC_IDX_W-1:0] idx);
        logic [DVS_W-1:0] s;
        case (idx)
            6'd1:    s = 15'd19707;
            6'd2:    s = 15'd13715;
            6'd3:    s = 15'd9659;
            6'd4:    s = 15'd6879;
            6'd5:    s = 15'd4953;
            6'd6:    s = 15'd3603;
            6'd7:    s = 15'd2647;
            6'd8:    s = 15'd1963;
            6'd9:    s = 15'd1469;
            6'd10:   s = 15'd1109;
            6'd11:   s = 15'd844;
            6'd12:   s = 15'd647;
            6'd13:   s = 15'd500;
            6'd14:   s = 15'd389;
            6'd15:   s = 15'd305;
            6'd16:   s = 15'd240;
            6'd17:   s = 15'd191;
            6'd18:   s = 15'd153;
            6'd19:   s = 15'd123;
            6'd20:   s = 15'd99;
            6'd21:   s = 15'd80;
            6'd22:   s = 15'd66;
            6'd23:   s = 15'd54;
            6'd24:   s = 15'd44;
            6'd25:   s = 15'd37;
            6'd26:   s = 15'd30;
            6'd27:   s = 15'd25;
            6'd28:   s = 15'd21;
            6'd29:   s = 15'd18;
            6'd30:   s = 15'd15;
            6'd31:   s = 15'd13;
            6'd32:   s = 15'd11;
            6'd33:   s = 15'd9;
            6'd34:   s = 15'd8;
            default: s = 15'd1;
        endcase
        return s;
    endfunction

endpackage

// ===== src/ntc_thermistor_temperature.sv =====
`timescale 1ns / 1ps

// ntc thermistor temperature: takes one 10-bit adc reading of the thermistor
// divider, scales it to centivolts (reading*322/1000), works out the thermistor
// resistance as v*13000/(330-v), walks the resistance table (-40 c to 130 c in
// 5 degree steps) for the first entry below it and interpolates linearly with
// the integer per-degree slope of that segment, clamped to -40..130; when no
// entry lies below the resistance the result is 130. one item is in flight at
// a time and runs from input transaction to result through the two multiplies,
// the reciprocal scaling and a 23-step resistance division on a shared
// one-bit-per-cycle divider, then the table walk at one entry per cycle, then
// the 23-step interpolation division and the hand-over (only the hand-over in
// the very hot case), plus any wait for the output register to free; the next
// reading is taken as soon as the result sits in the output register, even if
// it is not yet taken

module ntc_thermistor_temperature #(
    parameter int TABLE_ENTRIES = ntt_pkg::DEF_TABLE_ENTRIES
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [ntt_pkg::IN_DATA_W-1:0]  s_axis_tdata,  // [9:0] adc_sample
    // result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [ntt_pkg::OUT_DATA_W-1:0] m_axis_tdata   // [8:0] temperature_c, [31:9] ntc_ohms
);

    ntt_pkg::t_dp_cmd    w_cmd;
    ntt_pkg::t_dp_status w_status;
    logic signed [ntt_pkg::TEMP_W-1:0] w_temp;
    logic [ntt_pkg::OHMS_W-1:0]        w_ohms;

    // sequencing: one state per phase, divider passes counted in the controller
    ntt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    // multiplier, divider, table walk, interpolation and output register
    ntt_datapath #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_status        (w_status),
        .i_adc_sample    (s_axis_tdata[ntt_pkg::SAMPLE_W-1:0]),
        .i_out_ready     (m_axis_tready),
        .o_out_valid     (m_axis_tvalid),
        .o_temperature_c (w_temp),
        .o_ntc_ohms      (w_ohms)
    );

    // temperature in the low bits, resistance packed directly above
    assign m_axis_tdata = {w_ohms, w_temp};

    // the block is busy right after it takes a reading
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input accepted while previous reading still in work");

    // the reported temperature always lies in the clamped range
    a_temp_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> ($signed(m_axis_tdata[8:0]) >= -9'sd40 &&
                           $signed(m_axis_tdata[8:0]) <= 9'sd130))
        else $error("temperature out of range");

    // a resistance at or below the last table entry reads as the hot limit
    a_hot_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (m_axis_tdata[31:9] <= 23'd303)) |->
            (m_axis_tdata[8:0] == 9'd130))
        else $error("hot case not reported as 130");

    // resistance cannot exceed the value for the top divider reading
    a_ohms_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[31:9] <= 23'd4277000))
        else $error("resistance out of range");

endmodule

// ===== src/ntt_ctrl.sv =====
`timescale 1ns / 1ps

module ntt_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  ntt_pkg::t_dp_status i_status,
    output ntt_pkg::t_dp_cmd    o_cmd
);

    ntt_pkg::t_ctrl_state r_state, n_state;
    logic [ntt_pkg::CNT_W-1:0] r_cnt, n_cnt;
    logic w_cnt_last;

    assign w_cnt_last = (r_cnt == ntt_pkg::CNT_W'(ntt_pkg::DIV_STEPS - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ntt_pkg::ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        o_cmd.op   = ntt_pkg::OP_NONE;
        o_in_ready = 1'b0;
        case (r_state)
            ntt_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.op = ntt_pkg::OP_LOAD;
                    n_state  = ntt_pkg::ST_MUL_V;
                end
            end
            ntt_pkg::ST_MUL_V: begin
                o_cmd.op = ntt_pkg::OP_MUL_V;
                n_state  = ntt_pkg::ST_SCALE_V;
            end
            ntt_pkg::ST_SCALE_V: begin
                o_cmd.op = ntt_pkg::OP_SCALE_V;
                n_state  = ntt_pkg::ST_MUL_R;
            end
            ntt_pkg::ST_MUL_R: begin
                o_cmd.op = ntt_pkg::OP_MUL_R;
                n_state  = ntt_pkg::ST_DIVR_INIT;
            end
            ntt_pkg::ST_DIVR_INIT: begin
                o_cmd.op = ntt_pkg::OP_DIVR_INIT;
                n_cnt    = '0;
                n_state  = ntt_pkg::ST_DIV_R;
            end
            ntt_pkg::ST_DIV_R: begin
                o_cmd.op = ntt_pkg::OP_DIV_STEP;
                n_cnt    = r_cnt + 1'b1;
                if (w_cnt_last) begin
                    n_state = ntt_pkg::ST_SRCH_INIT;
                end
            end
            ntt_pkg::ST_SRCH_INIT: begin
                o_cmd.op = ntt_pkg::OP_SRCH_INIT;
                n_state  = ntt_pkg::ST_SEARCH;
            end
            ntt_pkg::ST_SEARCH: begin
                if (i_status.below) begin
                    o_cmd.op = ntt_pkg::OP_DIVT_INIT;
                    n_cnt    = '0;
                    n_state  = ntt_pkg::ST_DIV_T;
                end else if (i_status.last_idx) begin
                    o_cmd.op = ntt_pkg::OP_TEMP_HOT;
                    n_state  = ntt_pkg::ST_FINISH;
                end else begin
                    o_cmd.op = ntt_pkg::OP_SRCH_STEP;
                end
            end
            ntt_pkg::ST_DIV_T: begin
                o_cmd.op = ntt_pkg::OP_DIV_STEP;
                n_cnt    = r_cnt + 1'b1;
                if (w_cnt_last) begin
                    n_state = ntt_pkg::ST_TEMP;
                end
            end
            ntt_pkg::ST_TEMP: begin
                o_cmd.op = ntt_pkg::OP_TEMP_INTERP;
                n_state  = ntt_pkg::ST_FINISH;
            end
            ntt_pkg::ST_FINISH: begin
                if (i_status.out_free) begin
                    o_cmd.op = ntt_pkg::OP_PUSH;
                    n_state  = ntt_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = ntt_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ===== src/ntt_datapath.sv =====
`timescale 1ns / 1ps

module ntt_datapath #(
    parameter int TABLE_ENTRIES = ntt_pkg::DEF_TABLE_ENTRIES
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  ntt_pkg::t_dp_cmd               i_cmd,
    output ntt_pkg::t_dp_status            o_status,
    input  logic [ntt_pkg::SAMPLE_W-1:0]   i_adc_sample,
    input  logic                           i_out_ready,
    output logic                           o_out_valid,
    output logic signed [ntt_pkg::TEMP_W-1:0] o_temperature_c,
    output logic [ntt_pkg::OHMS_W-1:0]     o_ntc_ohms
);

    localparam int LIMIT = (TABLE_ENTRIES < ntt_pkg::NTC_TABLE_LEN) ?
                           TABLE_ENTRIES : ntt_pkg::NTC_TABLE_LEN;
    localparam int IW    = $clog2(LIMIT);

    logic [ntt_pkg::SAMPLE_W-1:0]  r_sample;
    logic [ntt_pkg::V_W-1:0]       r_v;
    logic [ntt_pkg::DIV_W-1:0]     r_prod;
    logic [ntt_pkg::OHMS_W-1:0]    r_ohms;
    logic [IW-1:0]                 r_idx;
    logic signed [ntt_pkg::TEMP_W-1:0] r_temp;

    // shared restoring divider: quotient shifts in as the dividend shifts out
    logic [ntt_pkg::DIV_W-1:0]     r_quo;
    logic [ntt_pkg::DVS_W-1:0]     r_rem;
    logic [ntt_pkg::DVS_W-1:0]     r_dvs;

    logic                          r_out_valid;
    logic signed [ntt_pkg::TEMP_W-1:0] r_out_temp;
    logic [ntt_pkg::OHMS_W-1:0]    r_out_ohms;

    logic [ntt_pkg::DVS_W:0]       w_rem_sh;
    logic                          w_ge;
    logic [ntt_pkg::V_W-1:0]       w_v;
    logic [ntt_pkg::SAMPLE_W-1:0]  w_mul_a;
    logic [ntt_pkg::MUL_B_W-1:0]   w_mul_b;
    logic [ntt_pkg::PROD_W-1:0]    w_prod;
    logic [ntt_pkg::V_RECIP_PROD_W-1:0] w_scale_prod;
    logic [ntt_pkg::NTC_IDX_W-1:0] w_idx6;
    logic [ntt_pkg::OHMS_W-1:0]    w_curve;
    logic [ntt_pkg::TEMP_W-1:0]    w_base;
    logic signed [ntt_pkg::DIV_W+1:0] w_t;
    logic signed [ntt_pkg::TEMP_W-1:0] w_t_clamp;
    logic                          w_out_free;

    assign w_rem_sh = {r_rem, r_quo[ntt_pkg::DIV_W-1]};
    assign w_ge     = (w_rem_sh >= {1'b0, r_dvs});

    // centivolts, clamped to the top of the divider range
    assign w_v = (r_quo > ntt_pkg::DIV_W'(ntt_pkg::V_MAX)) ?
                 ntt_pkg::V_W'(ntt_pkg::V_MAX) : r_quo[ntt_pkg::V_W-1:0];

    always_comb begin
        if (i_cmd.op == ntt_pkg::OP_MUL_R) begin
            w_mul_a = ntt_pkg::SAMPLE_W'(w_v);
            w_mul_b = ntt_pkg::MUL_B_W'(ntt_pkg::SERIES_OHMS);
        end else begin
            w_mul_a = r_sample;
            w_mul_b = ntt_pkg::MUL_B_W'(ntt_pkg::ADC_SCALE);
        end
    end

    assign w_prod  = ntt_pkg::PROD_W'(w_mul_a) * ntt_pkg::PROD_W'(w_mul_b);

    // reading*322 divided by 1000 through the reciprocal
    assign w_scale_prod = ntt_pkg::V_RECIP_PROD_W'(r_prod)
                        * ntt_pkg::V_RECIP_PROD_W'(ntt_pkg::V_RECIP);

    assign w_idx6  = ntt_pkg::NTC_IDX_W'(r_idx);
    assign w_curve = ntt_pkg::ntc_curve(w_idx6);
    assign w_base  = ntt_pkg::TEMP_W'(w_idx6) * ntt_pkg::TEMP_W'(ntt_pkg::TEMP_STEP);

    // segment base temperature minus the interpolated offset
    assign w_t = $signed({{(ntt_pkg::DIV_W + 2 - ntt_pkg::TEMP_W){1'b0}}, w_base})
               + (ntt_pkg::DIV_W + 2)'(ntt_pkg::TEMP_MIN)
               - $signed({2'b00, r_quo});

    always_comb begin
        if (w_t > (ntt_pkg::DIV_W + 2)'(ntt_pkg::TEMP_MAX)) begin
            w_t_clamp = ntt_pkg::TEMP_W'(ntt_pkg::TEMP_MAX);
        end else if (w_t < (ntt_pkg::DIV_W + 2)'(ntt_pkg::TEMP_MIN)) begin
            w_t_clamp = ntt_pkg::TEMP_W'(ntt_pkg::TEMP_MIN);
        end else begin
            w_t_clamp = w_t[ntt_pkg::TEMP_W-1:0];
        end
    end

    assign w_out_free = !r_out_valid || i_out_ready;

    assign o_status.below    = (w_curve < r_ohms);
    assign o_status.last_idx = (r_idx == IW'(LIMIT - 1));
    assign o_status.out_free = w_out_free;

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            ntt_pkg::OP_LOAD: begin
                r_sample <= i_adc_sample;
            end
            ntt_pkg::OP_MUL_V: begin
                r_prod <= w_prod[ntt_pkg::DIV_W-1:0];
            end
            ntt_pkg::OP_SCALE_V: begin
                r_quo <= ntt_pkg::DIV_W'(w_scale_prod >> ntt_pkg::V_RECIP_SH);
            end
            ntt_pkg::OP_DIV_STEP: begin
                r_quo <= {r_quo[ntt_pkg::DIV_W-2:0], w_ge};
                r_rem <= w_ge ? ntt_pkg::DVS_W'(w_rem_sh - {1'b0, r_dvs})
                              : w_rem_sh[ntt_pkg::DVS_W-1:0];
            end
            ntt_pkg::OP_MUL_R: begin
                r_v    <= w_v;
                r_prod <= w_prod[ntt_pkg::DIV_W-1:0];
            end
            ntt_pkg::OP_DIVR_INIT: begin
                r_quo <= r_prod;
                r_rem <= '0;
                r_dvs <= ntt_pkg::DVS_W'(ntt_pkg::REF_CV) - ntt_pkg::DVS_W'(r_v);
            end
            ntt_pkg::OP_SRCH_INIT: begin
                r_ohms <= r_quo;
                r_idx  <= IW'(1);
            end
            ntt_pkg::OP_SRCH_STEP: begin
                r_idx <= r_idx + 1'b1;
            end
            ntt_pkg::OP_DIVT_INIT: begin
                r_quo <= r_ohms - w_curve;
                r_rem <= '0;
                r_dvs <= ntt_pkg::ntc_slope(w_idx6);
            end
            ntt_pkg::OP_TEMP_HOT: begin
                r_temp <= ntt_pkg::TEMP_W'(ntt_pkg::TEMP_MAX);
            end
            ntt_pkg::OP_TEMP_INTERP: begin
                r_temp <= w_t_clamp;
            end
            ntt_pkg::OP_PUSH: begin
                r_out_temp <= r_temp;
                r_out_ohms <= r_ohms;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.op == ntt_pkg::OP_PUSH) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_temperature_c = r_out_temp;
    assign o_ntc_ohms      = r_out_ohms;

endmodule
